// File: sv/assert_macros.svh
// assertion macros shared by the console writer modules
// expects clk_i and rst_ni in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: sv/ccs_pkg.sv
// types and constants of the text console writer
// used by ccs_ctrl, ccs_datapath and the top level; no dependencies
package ccs_pkg;

  // fixed field widths of the words
  localparam int ADDR_W    = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int CELL_W    = 16;

  // item kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // character codes
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // cell written into the last row on scroll
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  // input word
  typedef struct packed {
    logic              kind;
    logic [7:0]        char_code;
    logic [7:0]        color;
    logic [ADDR_W-1:0] cell_address;
  } item_t;

  // result word
  typedef struct packed {
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [CELL_W-1:0]    cell_data;
    logic                 scrolled;
  } result_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;    // take the item on the input port
    logic rd_done;   // capture read data into the result
    logic clear_wr;  // write zero at the sweep counter
    logic copy_rd;   // read one row below the sweep counter
    logic fill_wr;   // write blank cell at the sweep counter
    logic cnt_zero;  // sweep counter to zero
    logic cnt_fill;  // sweep counter to start of last row
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_read;      // item on the port is a read
    logic will_scroll;  // item on the port is a put that scrolls
    logic cnt_last;     // sweep counter at the last cell
    logic cnt_copy_end; // sweep counter at the last copied cell
  } sts_t;

endpackage

// File: sv/text_console_cursor_scroll.sv
// top level of the text console writer: controller plus datapath
// depends on ccs_pkg, ccs_ctrl and ccs_datapath
//
//   port          dir  word                handshake
//   item_i        in   ccs_pkg::item_t     taken when start high and busy low
//   result_o      out  ccs_pkg::result_t   valid for the one cycle done_o is high
//
// a put that does not scroll leaves busy low: next item may follow at once,
//   its result is strobed in the following cycle
// a read passes through ST_READ, where the registered read port of the cell memory delivers its data
// a scroll holds busy through ST_COPY, ST_DRAIN and ST_FILL: one memory read and one write
//   per copied cell, a drain state, then one blank write per last-row cell
// after reset the cell memory is cleared to zero, cell by cell, with busy high
// results are strobed once and cannot be held off by the receiver
module text_console_cursor_scroll #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ccs_pkg::item_t   item_i,
  output logic             done_o,
  output ccs_pkg::result_t result_o
);

  ccs_pkg::cmd_t cmd;
  ccs_pkg::sts_t sts;

  // control
  ccs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // cell memory and cursor
  ccs_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule

// File: sv/ccs_ctrl.sv
// controller of the text console writer: clearing pass, item handling, scroll sweep
// depends on ccs_pkg and assert_macros.svh
`include "assert_macros.svh"

module ccs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output ccs_pkg::cmd_t cmd_o,
  input  ccs_pkg::sts_t sts_i
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_COPY  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_FILL  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_zero = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_read) begin
            state_d = ST_READ;
          end else if (sts_i.will_scroll) begin
            cmd_o.cnt_zero = 1'b1;
            state_d        = ST_COPY;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_done = 1'b1;
        done_d        = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_COPY: begin
        cmd_o.copy_rd = 1'b1;
        if (sts_i.cnt_copy_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last copy write goes out this cycle
        cmd_o.cnt_fill = 1'b1;
        state_d        = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_zero = 1'b1;
          done_d         = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

  // checks
  `ASSERT_HOLDS(a_read_done_two, (start && !busy && sts_i.is_read) |=> ##1 done_q)
  `ASSERT_HOLDS(a_put_done_one,
                (start && !busy && !sts_i.is_read && !sts_i.will_scroll) |=> done_q)
  `ASSERT_NEVER(a_no_done_in_clear, (state_q == ST_CLEAR) && done_q)

endmodule

// File: sv/ccs_datapath.sv
// datapath of the text console writer: cell memory, cursor, sweep counter, result
// depends on ccs_pkg and assert_macros.svh
`include "assert_macros.svh"

module ccs_datapath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ccs_pkg::item_t   item_i,
  input  ccs_pkg::cmd_t    cmd_i,
  output ccs_pkg::sts_t    sts_o,
  output ccs_pkg::result_t result_o
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  // one spare bit so the cell count itself fits for the range compare
  localparam int XW    = ((AW > ccs_pkg::ADDR_W) ? AW : ccs_pkg::ADDR_W) + 1;
  localparam int RO_W  = ccs_pkg::ROW_OUT_W;
  localparam int CO_W  = ccs_pkg::COL_OUT_W;
  localparam int DW    = ccs_pkg::CELL_W;

  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLS - 1);
  localparam logic [AW-1:0]    CNT_LAST  = AW'(CELLS - 1);
  localparam logic [AW-1:0]    COPY_LAST = AW'(CELLS - COLS - 1);
  localparam logic [AW-1:0]    FILL_BASE = AW'(CELLS - COLS);

  // cell memory
  logic [DW-1:0] mem [CELLS];
  logic [DW-1:0] rdata_q;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata;

  logic [ROW_W-1:0] row_q, row_n, put_row;
  logic [COL_W-1:0] col_q, col_n, put_col;
  logic [AW-1:0]    cnt_q;
  logic [AW-1:0]    cp_addr_q;
  logic             cp_valid_q;
  logic             in_range_q;
  logic             in_range;
  logic [XW-1:0]    addr_ext;
  logic [AW-1:0]    put_addr;
  logic [DW-1:0]    put_data;
  logic             put_wr;
  logic             is_put;
  logic             will_scroll;
  ccs_pkg::result_t res_q;

  assign is_put   = (item_i.kind == ccs_pkg::KIND_PUT);
  assign addr_ext = XW'(item_i.cell_address);
  assign in_range = (addr_ext < XW'(CELLS));

  // cursor step and target cell of a put
  always_comb begin
    row_n    = row_q;
    col_n    = col_q;
    put_row  = row_q;
    put_col  = col_q;
    put_data = {item_i.color, item_i.char_code};
    put_wr   = 1'b0;
    if (is_put) begin
      unique case (item_i.char_code)
        ccs_pkg::CH_BACKSPACE: begin
          if (col_q != '0) begin
            col_n = col_q - COL_W'(1);
          end else if (row_q != '0) begin
            row_n = row_q - ROW_W'(1);
            col_n = COL_LAST;
          end
          put_row  = row_n;
          put_col  = col_n;
          put_data = {item_i.color, ccs_pkg::CH_SPACE};
          put_wr   = 1'b1;
        end
        ccs_pkg::CH_NEWLINE: begin
          col_n = '0;
          if (row_q != ROW_LAST) begin
            row_n = row_q + ROW_W'(1);
          end
        end
        default: begin
          put_wr = 1'b1;
          if (col_q == COL_LAST) begin
            col_n = '0;
            if (row_q != ROW_LAST) begin
              row_n = row_q + ROW_W'(1);
            end
          end else begin
            col_n = col_q + COL_W'(1);
          end
        end
      endcase
    end
  end

  assign put_addr = AW'(put_row) * AW'(COLS) + AW'(put_col);

  // a put scrolls when it steps past the last row
  assign will_scroll = is_put && (row_q == ROW_LAST) &&
                       ((item_i.char_code == ccs_pkg::CH_NEWLINE) ||
                        ((item_i.char_code != ccs_pkg::CH_BACKSPACE) && (col_q == COL_LAST)));

  // memory write port select
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = '0;
    if (cmd_i.clear_wr) begin
      we = 1'b1;
    end else if (cmd_i.fill_wr) begin
      we    = 1'b1;
      wdata = ccs_pkg::BLANK_CELL;
    end else if (cp_valid_q) begin
      we    = 1'b1;
      waddr = cp_addr_q;
      wdata = rdata_q;
    end else if (cmd_i.accept && put_wr) begin
      we    = 1'b1;
      waddr = put_addr;
      wdata = put_data;
    end
  end

  // memory read port select
  always_comb begin
    re    = 1'b0;
    raddr = cnt_q + AW'(COLS);
    if (cmd_i.copy_rd) begin
      re = 1'b1;
    end else if (cmd_i.accept && !is_put && in_range) begin
      re    = 1'b1;
      raddr = AW'(addr_ext);
    end
  end

  // memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // cursor, sweep counter and pending copy write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      cnt_q      <= '0;
      cp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && is_put) begin
        row_q <= row_n;
        col_q <= col_n;
      end
      if (cmd_i.cnt_zero) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_fill) begin
        cnt_q <= FILL_BASE;
      end else if (cmd_i.clear_wr || cmd_i.copy_rd || cmd_i.fill_wr) begin
        cnt_q <= cnt_q + AW'(1);
      end
      cp_valid_q <= cmd_i.copy_rd;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_rd) begin
      cp_addr_q <= cnt_q;
    end
    if (cmd_i.accept) begin
      in_range_q         <= in_range;
      res_q.cursor_row   <= RO_W'(row_n);
      res_q.cursor_col   <= CO_W'(col_n);
      res_q.cell_data    <= '0;
      res_q.scrolled     <= will_scroll;
    end else if (cmd_i.rd_done) begin
      res_q.cell_data <= in_range_q ? rdata_q : '0;
    end
  end

  assign sts_o.is_read      = !is_put;
  assign sts_o.will_scroll  = will_scroll;
  assign sts_o.cnt_last     = (cnt_q == CNT_LAST);
  assign sts_o.cnt_copy_end = (cnt_q == COPY_LAST);
  assign result_o           = res_q;

  // checks
  `ASSERT_NEVER(a_copy_fill_overlap, cp_valid_q && cmd_i.fill_wr)
  `ASSERT_NEVER(a_accept_in_sweep,
                cmd_i.accept && (cmd_i.copy_rd || cmd_i.fill_wr || cmd_i.clear_wr))
  `ASSERT_HOLDS(a_row_in_range, row_q <= ROW_LAST)

endmodule

// File: tb/ccs_checker.sv
// checker of the text console writer: watches the input and result words,
// keeps its own copy of the screen and cursor, compares every result; needs ccs_pkg
module ccs_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  ccs_pkg::item_t   item_i,
  input  logic             done_i,
  input  ccs_pkg::result_t result_i,
  output int               err_cnt_o,
  output int               pend_cnt_o
);
  import ccs_pkg::*;

  localparam int CELL_COUNT = ROWS * COLS;
  localparam int MAX_REPORTS = 10;

  // shadow screen and cursor
  logic [CELL_W-1:0] screen_mem [CELL_COUNT];
  int                cur_row;
  int                cur_col;

  // results still owed by the block, oldest first
  result_t           owed_results [$];

  // apply one word to the shadow state and return the result it causes
  function automatic result_t console_step(item_t w);
    result_t r;
    int      i;
    r = '0;
    if (w.kind == KIND_READ) begin
      if (int'(w.cell_address) < CELL_COUNT) r.cell_data = screen_mem[w.cell_address];
    end else begin
      if (w.char_code == CH_BACKSPACE) begin
        // step back, wrap to the row above, stick at the top-left corner
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = COLS - 1;
        end
        screen_mem[cur_row * COLS + cur_col] = {w.color, CH_SPACE};
      end else if (w.char_code == CH_NEWLINE) begin
        cur_col = 0;
        cur_row++;
      end else begin
        screen_mem[cur_row * COLS + cur_col] = {w.color, w.char_code};
        cur_col++;
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      // scroll up one row, blank the last one
      if (cur_row >= ROWS) begin
        for (i = 0; i < CELL_COUNT - COLS; i++) screen_mem[i] = screen_mem[i + COLS];
        for (i = CELL_COUNT - COLS; i < CELL_COUNT; i++) screen_mem[i] = BLANK_CELL;
        cur_row = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end
    r.cursor_row = cur_row[ROW_OUT_W-1:0];
    r.cursor_col = cur_col[COL_OUT_W-1:0];
    return r;
  endfunction

  // compare results first, then predict for the word taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    int      i;
    if (!rst_ni) begin
      for (i = 0; i < CELL_COUNT; i++) screen_mem[i] = '0;
      cur_row = 0;
      cur_col = 0;
      owed_results.delete();
      err_cnt_o = 0;
      pend_cnt_o = 0;
    end else begin
      if (done_i) begin
        if (owed_results.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= MAX_REPORTS)
            $display("unexpected result word: row %0d col %0d data %h scrolled %b",
                     result_i.cursor_row, result_i.cursor_col,
                     result_i.cell_data, result_i.scrolled);
        end else begin
          want = owed_results.pop_front();
          if (result_i.cursor_row !== want.cursor_row ||
              result_i.cursor_col !== want.cursor_col ||
              result_i.cell_data  !== want.cell_data  ||
              result_i.scrolled   !== want.scrolled) begin
            err_cnt_o++;
            if (err_cnt_o <= MAX_REPORTS)
              $display({"result mismatch: want row %0d col %0d data %h scrolled %b, ",
                        "got row %0d col %0d data %h scrolled %b"},
                       want.cursor_row, want.cursor_col, want.cell_data, want.scrolled,
                       result_i.cursor_row, result_i.cursor_col,
                       result_i.cell_data, result_i.scrolled);
          end
        end
      end
      if (start_i && !busy_i) owed_results.push_back(console_step(item_i));
      pend_cnt_o = owed_results.size();
    end
  end

endmodule

// File: tb/tb.sv
// top of the console writer testbench: clock, reset, directed and random words
// instantiates text_console_cursor_scroll and ccs_checker; needs ccs_pkg
module tb;
  import ccs_pkg::*;

  localparam int COLS        = 80;
  localparam int ROWS        = 25;
  localparam int CELL_COUNT  = ROWS * COLS;
  localparam int ADDR_MAX    = (1 << ADDR_W) - 1;
  localparam int PHASE_WORDS = 183;
  localparam int DRAIN_LIMIT = 5000;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   cmd_word;
  logic    done;
  result_t res_word;
  int      err_cnt;
  int      pend_cnt;
  int      idle_pct [3] = '{18, 70, 0};

  text_console_cursor_scroll #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (cmd_word),
    .done_o  (done),
    .result_o(res_word)
  );

  ccs_checker #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_i    (busy),
    .item_i    (cmd_word),
    .done_i    (done),
    .result_i  (res_word),
    .err_cnt_o (err_cnt),
    .pend_cnt_o(pend_cnt)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit, far above the slowest correct run
  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // put word; the address field is ignored by the block, so it is random
  function automatic item_t put_word(logic [7:0] ch, logic [7:0] color);
    item_t w;
    w.kind = KIND_PUT;
    w.char_code = ch;
    w.color = color;
    w.cell_address = ADDR_W'($urandom_range(ADDR_MAX));
    return w;
  endfunction

  // read word with random character and color bits
  function automatic item_t read_word(int addr);
    item_t w;
    w.kind = KIND_READ;
    w.char_code = 8'($urandom_range(255));
    w.color = 8'($urandom_range(255));
    w.cell_address = ADDR_W'(addr);
    return w;
  endfunction

  // drive one word after a random gap and hold it until taken
  task automatic send_word(input item_t w, input int idle);
    @(negedge clk_i);
    while ($urandom_range(99) < idle) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    cmd_word = w;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    item_t w;
    int    r;
    int    ph;
    int    n;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_word = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: cleared buffer, out-of-range reads, cursor corner cases
    send_word(read_word(0), 0);
    send_word(read_word(CELL_COUNT - 1), 0);
    send_word(read_word(ADDR_MAX), 0);
    send_word(read_word(CELL_COUNT), 0);
    send_word(put_word(CH_BACKSPACE, 8'h5A), 0);  // backspace at top-left
    send_word(read_word(0), 0);
    send_word(put_word(8'hFF, 8'hFF), 0);
    send_word(put_word(8'h00, 8'h00), 0);
    send_word(put_word(8'h41, 8'h1E), 18);
    send_word(put_word(CH_BACKSPACE, 8'h07), 18);
    send_word(put_word(CH_NEWLINE, 8'hA5), 18);
    send_word(put_word(CH_BACKSPACE, 8'h33), 18); // backspace at column 0
    send_word(put_word(8'h7E, 8'hC3), 18);        // print in the last column
    send_word(read_word(COLS - 1), 18);
    send_word(read_word(1), 0);
    send_word(read_word(2), 0);
    send_word(read_word(COLS), 0);
    send_word(put_word(CH_NEWLINE, 8'h00), 0);
    send_word(put_word(8'h20, 8'h70), 0);
    send_word(read_word(2 * COLS), 0);

    // random words in three idling phases
    for (ph = 0; ph < 3; ph++) begin
      for (n = 0; n < PHASE_WORDS; n++) begin
        r = $urandom_range(99);
        if (r < 25) begin
          if ($urandom_range(99) < 90) w = read_word(int'($urandom_range(CELL_COUNT - 1)));
          else w = read_word(int'($urandom_range(ADDR_MAX, CELL_COUNT)));
        end else if (r < 40) begin
          w = put_word(CH_NEWLINE, 8'($urandom_range(255)));
        end else if (r < 48) begin
          w = put_word(CH_BACKSPACE, 8'($urandom_range(255)));
        end else begin
          w = put_word(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        send_word(w, idle_pct[ph]);
      end
      // hold off until the block has answered everything
      if (ph == 0) begin
        @(negedge clk_i);
        start = 1'b0;
        wait (pend_cnt == 0);
      end
    end

    // drain, then keep watching for stray results
    @(negedge clk_i);
    start = 1'b0;
    for (n = 0; n < DRAIN_LIMIT && pend_cnt != 0; n++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pend_cnt != 0) $display("results never arrived: %0d", pend_cnt);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
